// ===== sv/mfsp_pkg.sv =====
// Package for the MIDI file stream parser: types, codes and helper functions.
`timescale 1ns / 1ps
`default_nettype none
package mfsp_pkg;

  localparam int unsigned VlqMaxBytesDefault = 4;
  localparam logic [23:0] MaxTempoReset = 24'hFFFFFF;

  typedef enum logic [2:0] {
    REC_HEADER  = 3'd0,
    REC_CHANNEL = 3'd1,
    REC_META    = 3'd2,
    REC_SYSEX   = 3'd3,
    REC_PAYLOAD = 3'd4,
    REC_EOT     = 3'd5,
    REC_EOF     = 3'd6,
    REC_ERROR   = 3'd7
  } rec_kind_e;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b00000000001,
    PH_HDR     = 11'b00000000010,
    PH_TRK     = 11'b00000000100,
    PH_DELTA   = 11'b00000001000,
    PH_STATUS  = 11'b00000010000,
    PH_P1      = 11'b00000100000,
    PH_P2      = 11'b00001000000,
    PH_MTYPE   = 11'b00010000000,
    PH_LEN     = 11'b00100000000,
    PH_PAYLOAD = 11'b01000000000,
    PH_SKIP    = 11'b10000000000
  } phase_e;

  localparam logic [7:0] StMeta     = 8'hFF;
  localparam logic [7:0] StSysex    = 8'hF0;
  localparam logic [7:0] StSysexEsc = 8'hF7;
  localparam logic [7:0] MetaEot    = 8'h2F;
  localparam logic [7:0] MetaTempo  = 8'h51;
  localparam logic [7:0] MetaSmpte  = 8'h54;
  localparam logic [7:0] MetaTime   = 8'h58;
  localparam logic [7:0] MetaKey    = 8'h59;
  localparam logic [7:0] MetaSeqSp  = 8'h7F;
  localparam logic [7:0] MetaChPfx  = 8'h20;
  localparam logic [7:0] MetaPort   = 8'h21;
  localparam logic [7:0] MetaSeqNum = 8'h00;

  // One result record.
  typedef struct packed {
    rec_kind_e   kind;
    logic [27:0] delta_ticks;
    logic [3:0]  type_nibble;
    logic [3:0]  channel;
    logic [6:0]  param1;
    logic [6:0]  param2;
    logic [7:0]  meta_type;
    logic [27:0] payload_len;
    logic [7:0]  data_byte;
    logic [1:0]  header_format;
    logic [15:0] track_number;
    logic [15:0] time_division;
  } rec_t;

  // Meta length rule: known flag, any-length flag, fixed length.
  typedef struct packed {
    logic       known;
    logic       any_len;
    logic [2:0] fixed;
  } meta_len_t;

  function automatic meta_len_t meta_len(input logic [7:0] t);
    meta_len_t r;
    r = '{known: 1'b1, any_len: 1'b0, fixed: 3'd0};
    unique case (t)
      MetaSeqNum: r.fixed = 3'd2;
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, MetaSeqSp:
        r.any_len = 1'b1;
      MetaChPfx, MetaPort: r.fixed = 3'd1;
      MetaEot:   r.fixed = 3'd0;
      MetaTempo: r.fixed = 3'd3;
      MetaSmpte: r.fixed = 3'd5;
      MetaTime:  r.fixed = 3'd4;
      MetaKey:   r.fixed = 3'd2;
      default:   r.known = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] smpte_frame_limit(input logic [1:0] code);
    logic [7:0] r;
    unique case (code)
      2'd0:    r = 8'd23;
      2'd1:    r = 8'd24;
      default: r = 8'd29;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mfsp_core.sv =====
// Parse state and next-state logic: one byte in, at most one record out.
`timescale 1ns / 1ps
`default_nettype none
module mfsp_core #(
  parameter int unsigned VlqMaxBytes = mfsp_pkg::VlqMaxBytesDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic           file_start_i,
  input  wire logic [23:0]    max_tempo_i,
  output logic                rec_valid_o,
  output mfsp_pkg::rec_t      rec_o
);
  import mfsp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [31:0] left_q, left_d;
  logic [15:0] tracks_q, tracks_d;
  logic [15:0] tidx_q, tidx_d;
  logic [7:0]  rs_q, rs_d;
  logic [27:0] vlq_q, vlq_d;
  logic [27:0] delta_q, delta_d;
  logic [7:0]  htype_q, htype_d;
  logic [27:0] pleft_q, pleft_d;
  logic [31:0] hbytes_q, hbytes_d;
  logic [1:0]  hfmt_q, hfmt_d;

  // Values with file_start applied.
  phase_e      ph;
  logic [3:0]  fbc;
  logic [31:0] left, hb;
  logic [15:0] tracks, tidx;
  logic [7:0]  rs, ht;
  logic [27:0] vlq, dl, pl;
  logic [1:0]  hf;

  logic [31:0] hb_sh;
  logic [15:0] w;
  logic [27:0] vlq_new;
  logic [3:0]  fbc_inc;
  logic        vlq_done, vlq_long;
  logic [31:0] left_dec;
  logic        err, rec, pbad, end_normal, end_quiet;
  logic [3:0]  nib;
  meta_len_t   ml;
  rec_t        r;
  logic [15:0] tracks_dec;

  always_comb begin
    ph = phase_q; fbc = fbc_q; left = left_q; hb = hbytes_q; tracks = tracks_q;
    tidx = tidx_q; rs = rs_q; ht = htype_q; vlq = vlq_q; dl = delta_q;
    pl = pleft_q; hf = hfmt_q;
    if (file_start_i) begin
      ph = PH_HDR; fbc = '0; left = '0; hb = '0; tracks = '0; tidx = '0;
      rs = '0; ht = '0; vlq = '0; dl = '0; pl = '0; hf = '0;
    end
  end

  always_comb begin
    hb_sh    = {hb[23:0], in_byte_i};
    w        = hb_sh[15:0];
    fbc_inc  = fbc + 4'd1;
    vlq_new  = {vlq[20:0], in_byte_i[6:0]};
    vlq_done = ~in_byte_i[7];
    vlq_long = in_byte_i[7] && ({28'd0, fbc_inc} >= 32'(VlqMaxBytes));
    left_dec = left - 32'd1;
    nib      = ht[7:4];
    ml       = meta_len(ht);
    tracks_dec = (tracks != 16'd0) ? tracks - 16'd1 : 16'd0;

    pbad = 1'b0;
    if (ht == MetaChPfx && pl == 28'd1) pbad = in_byte_i > 8'd15;
    else if (ht == MetaTempo && pl == 28'd1) pbad = {hb[15:0], in_byte_i} > max_tempo_i;
    else if (ht == MetaSmpte && pl == 28'd5)
      pbad = in_byte_i[7] || ({3'd0, in_byte_i[4:0]} > 8'd23);
    else if (ht == MetaSmpte && pl == 28'd2)
      pbad = in_byte_i > smpte_frame_limit(hb[22:21]);
    else if (ht == MetaTime && pl == 28'd1) pbad = in_byte_i == 8'd0;
    else if (ht == MetaKey && pl == 28'd2) pbad = in_byte_i > 8'd7 && in_byte_i < 8'hF9;
    else if (ht == MetaKey && pl == 28'd1) pbad = in_byte_i > 8'd1;
  end

  always_comb begin
    phase_d = ph; fbc_d = fbc; left_d = left; hbytes_d = hb; tracks_d = tracks;
    tidx_d = tidx; rs_d = rs; htype_d = ht; vlq_d = vlq; delta_d = dl;
    pleft_d = pl; hfmt_d = hf;
    r = '0;
    r.kind = REC_HEADER;
    err = 1'b0; rec = 1'b0;
    end_normal = 1'b0; end_quiet = 1'b0;

    unique case (ph)
      PH_IDLE: ;
      PH_HDR: begin
        hbytes_d = hb_sh; fbc_d = fbc_inc;
        if (fbc == 4'd3 && hb_sh != 32'h4D546864) err = 1'b1;
        if (fbc == 4'd7 && hb_sh != 32'h00000006) err = 1'b1;
        if (fbc == 4'd9) begin
          if (w > 16'd2) err = 1'b1;
          hfmt_d = w[1:0];
        end
        if (fbc == 4'd11) begin
          if (w == 16'd0 || (hf == 2'd0 && w != 16'd1)) err = 1'b1;
          tracks_d = w;
        end
        if (fbc == 4'd13) begin
          rec = 1'b1;
          r.kind = REC_HEADER; r.header_format = hf;
          r.track_number = tracks; r.time_division = w;
          phase_d = PH_TRK; fbc_d = '0; hbytes_d = '0;
        end
      end
      PH_TRK: begin
        hbytes_d = hb_sh; fbc_d = fbc_inc;
        if (fbc == 4'd3 && hb_sh != 32'h4D54726B) err = 1'b1;
        if (fbc == 4'd7) begin
          left_d = hb_sh; rs_d = '0;
          if (hb_sh == 32'd0) end_normal = 1'b1;
          else begin phase_d = PH_DELTA; vlq_d = '0; fbc_d = '0; end
        end
      end
      default: begin
        if (left == 32'd0) err = 1'b1;
        else begin
          left_d = left_dec;
          unique case (ph)
            PH_DELTA: begin
              vlq_d = vlq_new; fbc_d = fbc_inc;
              if (vlq_done) begin delta_d = vlq_new; phase_d = PH_STATUS; end
              else if (vlq_long) err = 1'b1;
            end
            PH_STATUS, PH_P1: begin
              logic [7:0] t;
              logic       p1;
              t = ht; p1 = (ph == PH_P1);
              if (ph == PH_STATUS) begin
                if (in_byte_i == StMeta) begin rs_d = '0; phase_d = PH_MTYPE; end
                else if (in_byte_i == StSysex || in_byte_i == StSysexEsc) begin
                  rs_d = '0; htype_d = in_byte_i; phase_d = PH_LEN;
                  vlq_d = '0; fbc_d = '0;
                end else if (in_byte_i >= 8'hF0) err = 1'b1;
                else if (in_byte_i[7]) begin
                  rs_d = in_byte_i; htype_d = in_byte_i; phase_d = PH_P1;
                end else if (rs == 8'd0) err = 1'b1;
                else begin htype_d = rs; t = rs; p1 = 1'b1; end
              end
              if (p1) begin
                if (in_byte_i[7]) err = 1'b1;
                else if (t[7:4] == 4'hC || t[7:4] == 4'hD) begin
                  rec = 1'b1; r.kind = REC_CHANNEL; r.delta_ticks = dl;
                  r.type_nibble = t[7:4]; r.channel = t[3:0];
                  r.param1 = in_byte_i[6:0]; r.track_number = tidx;
                  phase_d = PH_DELTA; vlq_d = '0; fbc_d = '0;
                end else if (t[7:4] < 4'h8 || t[7:4] > 4'hE) err = 1'b1;
                else begin hbytes_d = {24'd0, in_byte_i}; phase_d = PH_P2; end
              end
            end
            PH_P2: begin
              if (in_byte_i[7]) err = 1'b1;
              else begin
                rec = 1'b1; r.kind = REC_CHANNEL; r.delta_ticks = dl;
                r.type_nibble = nib; r.channel = ht[3:0];
                r.param1 = hb[6:0]; r.param2 = in_byte_i[6:0];
                r.track_number = tidx;
                phase_d = PH_DELTA; vlq_d = '0; fbc_d = '0;
              end
            end
            PH_MTYPE: begin
              if (!meta_len(in_byte_i).known) err = 1'b1;
              else begin
                htype_d = in_byte_i; phase_d = PH_LEN; vlq_d = '0; fbc_d = '0;
              end
            end
            PH_LEN: begin
              vlq_d = vlq_new; fbc_d = fbc_inc;
              if (!vlq_done) begin
                if (vlq_long) err = 1'b1;
              end else if (ht != StSysex && ht != StSysexEsc && !ml.any_len &&
                           vlq_new != {25'd0, ml.fixed}) begin
                err = 1'b1;
              end else if (ht == MetaEot) begin
                if (left_dec == 32'd0) begin
                  phase_d = PH_DELTA; vlq_d = '0; fbc_d = '0;
                end else begin
                  rec = 1'b1; r.kind = REC_EOT; r.track_number = tidx;
                  phase_d = PH_SKIP;
                end
              end else begin
                rec = 1'b1;
                r.kind = (ht == StSysex || ht == StSysexEsc) ? REC_SYSEX : REC_META;
                r.delta_ticks = dl; r.meta_type = ht; r.payload_len = vlq_new;
                r.track_number = tidx;
                pleft_d = vlq_new; hbytes_d = '0;
                if (vlq_new == 28'd0) begin
                  phase_d = PH_DELTA; vlq_d = '0; fbc_d = '0;
                end else phase_d = PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              if (pbad) err = 1'b1;
              else begin
                rec = 1'b1; r.kind = REC_PAYLOAD; r.delta_ticks = dl;
                r.meta_type = ht; r.data_byte = in_byte_i; r.track_number = tidx;
                hbytes_d = hb_sh; pleft_d = pl - 28'd1;
                if (pl == 28'd1) begin phase_d = PH_DELTA; vlq_d = '0; fbc_d = '0; end
              end
            end
            default: ; // skip: budget only
          endcase
          if (!err && left_dec == 32'd0) begin
            if (phase_d == PH_DELTA) end_normal = 1'b1;
            else if (phase_d == PH_SKIP) end_quiet = 1'b1;
            else err = 1'b1;
          end
        end
      end
    endcase

    if (err) begin
      r = '0; r.kind = REC_ERROR; r.track_number = tidx;
      rec = 1'b1; phase_d = PH_IDLE;
    end else if (end_normal || end_quiet) begin
      r = '0; r.track_number = tidx;
      tracks_d = tracks_dec;
      if (tracks_dec == 16'd0) begin
        r.kind = REC_EOF; rec = 1'b1; phase_d = PH_IDLE;
      end else begin
        r.kind = REC_EOT; rec = end_normal;
        phase_d = PH_TRK; fbc_d = '0; hbytes_d = '0; tidx_d = tidx + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; fbc_q <= '0; left_q <= '0; tracks_q <= '0;
      tidx_q <= '0; rs_q <= '0; vlq_q <= '0; delta_q <= '0; htype_q <= '0;
      pleft_q <= '0; hbytes_q <= '0; hfmt_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; fbc_q <= fbc_d; left_q <= left_d; tracks_q <= tracks_d;
      tidx_q <= tidx_d; rs_q <= rs_d; vlq_q <= vlq_d; delta_q <= delta_d;
      htype_q <= htype_d; pleft_q <= pleft_d; hbytes_q <= hbytes_d; hfmt_q <= hfmt_d;
    end
  end

  assign rec_valid_o = rec;
  assign rec_o       = r;

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_IDLE && !file_start_i) |-> !rec_valid_o)
    else $error("record from idle phase");
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && rec_valid_o && rec_o.kind == REC_ERROR) |=> phase_q == PH_IDLE)
    else $error("error did not return to idle");
  a_eof_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && rec_valid_o && rec_o.kind == REC_EOF) |=> phase_q == PH_IDLE)
    else $error("end-of-file did not return to idle");
`endif
endmodule
`default_nettype wire

// ===== sv/midi_file_stream_parser.sv =====
// Top level of the MIDI file stream parser: input register, parse core, result register.
`timescale 1ns / 1ps
`default_nettype none
// Standard MIDI File parser taking one byte per transfer. A byte is registered, parsed
// against the held state in a single pass and its record (if any) is loaded into the
// output register, so a byte can enter every cycle: throughput is one byte per clock
// while the output side keeps stall low. The input stalls only when both the input
// and output registers are full and the output is stalled. max_tempo is written over
// its own valid/ready port and should only be changed while no byte is in flight.
// After an error or end-of-file the parser ignores bytes until one arrives with
// file_start set.
module midi_file_stream_parser #(
  parameter int unsigned VlqMaxBytes = mfsp_pkg::VlqMaxBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        file_start_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [23:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       rec_kind_o,
  output logic [27:0]      delta_ticks_o,
  output logic [3:0]       type_nibble_o,
  output logic [3:0]       channel_o,
  output logic [6:0]       param1_o,
  output logic [6:0]       param2_o,
  output logic [7:0]       meta_type_o,
  output logic [27:0]      payload_len_o,
  output logic [7:0]       data_byte_o,
  output logic [1:0]       header_format_o,
  output logic [15:0]      track_number_o,
  output logic [15:0]      time_division_o
);
  import mfsp_pkg::*;

  logic [23:0] max_tempo_q;
  logic        ib_valid_q;
  logic [7:0]  ib_byte_q;
  logic        ib_start_q;
  logic        ov_q;
  rec_t        or_q;
  logic        step, out_free, rec_valid;
  rec_t        rec;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_tempo_q <= MaxTempoReset;
    else if (cfg_valid_i) max_tempo_q <= cfg_data_i;
  end

  // Output register is free when empty or being drained this cycle.
  assign out_free   = !ov_q || !out_stall_i;
  assign step       = ib_valid_q && out_free;
  assign in_stall_o = ib_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ib_valid_q <= 1'b0;
    else if (!in_stall_o) ib_valid_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ib_byte_q  <= in_byte_i;
      ib_start_q <= file_start_i;
    end
  end

  mfsp_core #(.VlqMaxBytes(VlqMaxBytes)) u_core (
    .clk_i, .rst_ni,
    .step_i       (step),
    .in_byte_i    (ib_byte_q),
    .file_start_i (ib_start_q),
    .max_tempo_i  (max_tempo_q),
    .rec_valid_o  (rec_valid),
    .rec_o        (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (out_free) ov_q <= step && rec_valid;
  end
  always_ff @(posedge clk_i) begin
    if (step && rec_valid) or_q <= rec;
  end

  assign out_valid_o     = ov_q;
  assign rec_kind_o      = or_q.kind;
  assign delta_ticks_o   = or_q.delta_ticks;
  assign type_nibble_o   = or_q.type_nibble;
  assign channel_o       = or_q.channel;
  assign param1_o        = or_q.param1;
  assign param2_o        = or_q.param2;
  assign meta_type_o     = or_q.meta_type;
  assign payload_len_o   = or_q.payload_len;
  assign data_byte_o     = or_q.data_byte;
  assign header_format_o = or_q.header_format;
  assign track_number_o  = or_q.track_number;
  assign time_division_o = or_q.time_division;

`ifndef SYNTHESIS
  a_no_step_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |-> !step)
    else $error("parse step while output held");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(rec_kind_o))
    else $error("stalled record changed");
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (ib_valid_q && ov_q && out_stall_i))
    else $error("input stalled without cause");
`endif
endmodule
`default_nettype wire
